// ===== rtl/datt_pkg.sv =====
package datt_pkg;

	// Width used for index and count compares inside the cells; covers table depths up to 255.
	localparam int CMP_W = 8;

	// Field widths of one record.
	localparam int ADDR_W = 48;
	localparam int KIND_W = 8;
	localparam int STAMP_W = 32;

	// Command codes carried on the cmd port.
	typedef enum logic [1:0] {
		CMD_UPSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_CLEAR  = 2'd3
	} datt_cmd_t;

	// One device record.
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [KIND_W-1:0]  kind;
		logic [STAMP_W-1:0] stamp;
	} datt_rec_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic             upsert;
		logic             remove;
		logic             hit;
		logic             full;
		logic [CMP_W-1:0] count;
		logic [CMP_W-1:0] idx;
	} datt_ctrl_t;

endpackage

// ===== rtl/datt_cell.sv =====
module datt_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  datt_pkg::datt_ctrl_t ctrl,
	input  datt_pkg::datt_rec_t  req_rec,
	input  datt_pkg::datt_rec_t  nxt_rec,
	output datt_pkg::datt_rec_t  rec,
	output logic                 match
);
	import datt_pkg::*;

	localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] NXT_C = CMP_W'(IDX + 1);

	datt_rec_t rec_q;
	logic      in_range;
	logic      do_shift;
	logic      do_append;
	logic      do_refresh;

	// Only slots below the count hold live records, so only they may match.
	assign in_range = IDX_C < ctrl.count;
	assign match    = in_range && (rec_q.addr == req_rec.addr);
	assign rec      = rec_q;

	// A remove pulls the neighbor's record into every slot from the removed one up to the one below the last live slot.
	assign do_shift   = ctrl.remove && (IDX_C >= ctrl.idx) && (NXT_C < ctrl.count);
	assign do_append  = ctrl.upsert && !ctrl.hit && !ctrl.full && (IDX_C == ctrl.count);
	assign do_refresh = ctrl.upsert && match;

	// Record storage; it needs no reset since the count marks what is live.
	always_ff @(posedge clk) begin
		if (do_shift) begin
			rec_q <= nxt_rec;
		end else if (do_append) begin
			rec_q <= req_rec;
		end else if (do_refresh) begin
			rec_q.kind  <= req_rec.kind;
			rec_q.stamp <= req_rec.stamp;
		end
	end

endmodule

// ===== rtl/device_address_table_core.sv =====
// Device address table: a packed list of up to MAX_ENTRIES records, each an address,
// an address type and a last-seen stamp, kept as a row of cells in slots 0 .. count-1.
// A request is taken at a rising edge with start high and busy low; cmd selects upsert,
// remove by index, get by index or clear, and the other inputs carry its operands.
// Busy stays low: a new request may be issued in every cycle.
// The request is registered, the cells compare all addresses and update in the next cycle,
// and the result is registered at the end of that cycle.
// done is then high for exactly one cycle with ok, was_hit, slot, the read fields and
// entry_total; fields a command does not produce read zero.
// Throughput is one request per cycle, set by the single compare-and-update step of
// the cell row; each request sees every earlier one applied.
// The receiver cannot hold results off; each result is valid only in its done cycle.
// Reset empties the table at once (count zero) and drops any request in flight.
module device_address_table_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [47:0] dev_addr,
	input  logic [7:0]  dev_kind,
	input  logic [31:0] now_time,
	input  logic [3:0]  slot_index,
	output logic        done,
	output logic        ok,
	output logic        was_hit,
	output logic [3:0]  slot,
	output logic [47:0] rd_addr,
	output logic [7:0]  rd_kind,
	output logic [31:0] rd_time,
	output logic [4:0]  entry_total
);
	import datt_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	// Request stage.
	logic            req_s1;
	datt_cmd_t       cmd_s1;
	datt_rec_t       rec_s1;
	logic [3:0]      idx_s1;

	// Table state and cell row.
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_nxt;
	datt_rec_t       cell_rec [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match;
	datt_ctrl_t      ctrl;
	logic            hit;
	logic            full;
	logic            idx_ok;
	logic [IW-1:0]   hit_slot;
	logic [IW-1:0]   rd_idx;
	datt_rec_t       rd_rec;

	// Result registers.
	logic            done_q;
	logic            ok_q;
	logic            hit_q;
	logic [3:0]      slot_q;
	datt_rec_t       rd_q;
	logic [4:0]      total_q;

	assign busy = 1'b0;

	// Register the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= 1'b0;
		end else begin
			req_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1       <= datt_cmd_t'(cmd);
			rec_s1.addr  <= dev_addr;
			rec_s1.kind  <= dev_kind;
			rec_s1.stamp <= now_time;
			idx_s1       <= slot_index;
		end
	end

	// Lookup results; live addresses are unique, so an OR encode finds the hit slot.
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i]) begin
				hit_slot = hit_slot | IW'(i);
			end
		end
	end

	assign hit    = |match;
	assign full   = count_q == CW'(MAX_ENTRIES);
	assign idx_ok = CMP_W'(idx_s1) < CMP_W'(count_q);
	assign rd_idx = IW'(idx_s1);
	assign rd_rec = cell_rec[rd_idx];

	// Control broadcast to the cells.
	always_comb begin
		ctrl.upsert = req_s1 && (cmd_s1 == CMD_UPSERT);
		ctrl.remove = req_s1 && (cmd_s1 == CMD_REMOVE) && idx_ok;
		ctrl.hit    = hit;
		ctrl.full   = full;
		ctrl.count  = CMP_W'(count_q);
		ctrl.idx    = CMP_W'(idx_s1);
	end

	// Row of cells, each fed by its upper neighbor for the remove shift.
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		datt_rec_t nxt;
		if (g < MAX_ENTRIES - 1) begin : g_mid
			assign nxt = cell_rec[g + 1];
		end else begin : g_end
			assign nxt = '0;
		end
		datt_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.req_rec(rec_s1),
			.nxt_rec(nxt),
			.rec    (cell_rec[g]),
			.match  (match[g])
		);
	end

	// Next count.
	always_comb begin
		count_nxt = count_q;
		if (req_s1) begin
			unique case (cmd_s1)
				CMD_UPSERT: begin
					if (!hit && !full) begin
						count_nxt = count_q + CW'(1);
					end
				end
				CMD_REMOVE: begin
					if (idx_ok) begin
						count_nxt = count_q - CW'(1);
					end
				end
				CMD_GET:   count_nxt = count_q;
				CMD_CLEAR: count_nxt = '0;
				default:   count_nxt = count_q;
			endcase
		end
	end

	// Count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= req_s1;
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (req_s1) begin
			ok_q    <= 1'b0;
			hit_q   <= 1'b0;
			slot_q  <= '0;
			rd_q    <= '0;
			total_q <= 5'(count_nxt);
			unique case (cmd_s1)
				CMD_UPSERT: begin
					if (hit) begin
						ok_q   <= 1'b1;
						hit_q  <= 1'b1;
						slot_q <= 4'(hit_slot);
					end else if (!full) begin
						ok_q   <= 1'b1;
						slot_q <= 4'(count_q);
					end
				end
				CMD_REMOVE: ok_q <= idx_ok;
				CMD_GET: begin
					if (idx_ok) begin
						ok_q   <= 1'b1;
						slot_q <= idx_s1;
						rd_q   <= rd_rec;
					end
				end
				CMD_CLEAR: ok_q <= 1'b1;
				default:   ok_q <= 1'b0;
			endcase
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign was_hit     = hit_q;
	assign slot        = slot_q;
	assign rd_addr     = rd_q.addr;
	assign rd_kind     = rd_q.kind;
	assign rd_time     = rd_q.stamp;
	assign entry_total = total_q;

	// The count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above table depth");

	// Live addresses are unique, so at most one cell matches.
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		!req_s1 || $onehot0(match))
		else $error("more than one live cell matches the request address");

	// Every accepted request gives its result through the request and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request result missing");

	// A failed request reports no slot and no read data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (slot == 4'd0 && !was_hit && rd_addr == 48'd0))
		else $error("failed request carries result data");

endmodule

// ===== verif/device_address_table_core_tb.sv =====
`timescale 1ns / 100ps

module device_address_table_core_tb;
	import datt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RAND_ITEMS = 1600;
	localparam int CALM_TAIL = 300;
	localparam int POOL_SIZE = 24;

	// One reply of the table, laid out in port order.
	typedef struct packed {
		logic        ok;
		logic        hit;
		logic [3:0]  slot;
		logic [47:0] addr;
		logic [7:0]  kind;
		logic [31:0] stamp;
		logic [4:0]  total;
	} table_reply_t;

	// Shadow copy of the device table; predicts each reply and checks the
	// replies in request order.
	class address_table_tracker;
		logic [47:0] addr_tab[TABLE_DEPTH];
		logic [7:0] kind_tab[TABLE_DEPTH];
		logic [31:0] stamp_tab[TABLE_DEPTH];
		int unsigned live_count;
		table_reply_t pending_replies[$];
		int unsigned faults, replies_seen;
		int unsigned n_requests, n_hits, n_appends, n_full, n_range_miss;
		int unsigned n_removes, n_gets, n_clears, peak_count;

		function new();
			live_count = 0;
			faults = 0;
			replies_seen = 0;
			n_requests = 0;
			n_hits = 0;
			n_appends = 0;
			n_full = 0;
			n_range_miss = 0;
			n_removes = 0;
			n_gets = 0;
			n_clears = 0;
			peak_count = 0;
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10) begin
				$display("[%0t] MISMATCH %s", $realtime, msg);
			end
		endfunction

		function int unsigned pending();
			return pending_replies.size();
		endfunction

		// Apply one accepted request to the shadow table and queue its reply.
		function void log_request(datt_cmd_t op, logic [47:0] a, logic [7:0] k,
				logic [31:0] t, logic [3:0] idx);
			table_reply_t want;
			int found;
			want = '0;
			found = -1;
			n_requests++;
			case (op)
				CMD_UPSERT: begin
					// The search takes the lowest matching slot.
					for (int i = 0; i < live_count; i++) begin
						if (found < 0 && addr_tab[i] == a) begin
							found = i;
						end
					end
					if (found >= 0) begin
						kind_tab[found] = k;
						stamp_tab[found] = t;
						want.ok = 1'b1;
						want.hit = 1'b1;
						want.slot = found[3:0];
						n_hits++;
					end else if (live_count < TABLE_DEPTH) begin
						addr_tab[live_count] = a;
						kind_tab[live_count] = k;
						stamp_tab[live_count] = t;
						want.ok = 1'b1;
						want.slot = live_count[3:0];
						live_count++;
						n_appends++;
					end else begin
						n_full++;
					end
				end
				CMD_REMOVE: begin
					if (idx < live_count) begin
						// Later records move down by one.
						for (int i = idx; i + 1 < live_count; i++) begin
							addr_tab[i] = addr_tab[i + 1];
							kind_tab[i] = kind_tab[i + 1];
							stamp_tab[i] = stamp_tab[i + 1];
						end
						live_count--;
						addr_tab[live_count] = '0;
						kind_tab[live_count] = '0;
						stamp_tab[live_count] = '0;
						want.ok = 1'b1;
						n_removes++;
					end else begin
						n_range_miss++;
					end
				end
				CMD_GET: begin
					if (idx < live_count) begin
						want.ok = 1'b1;
						want.slot = idx;
						want.addr = addr_tab[idx];
						want.kind = kind_tab[idx];
						want.stamp = stamp_tab[idx];
						n_gets++;
					end else begin
						n_range_miss++;
					end
				end
				default: begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						addr_tab[i] = '0;
						kind_tab[i] = '0;
						stamp_tab[i] = '0;
					end
					live_count = 0;
					want.ok = 1'b1;
					n_clears++;
				end
			endcase
			if (live_count > peak_count) begin
				peak_count = live_count;
			end
			want.total = live_count[4:0];
			pending_replies.push_back(want);
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				flag($sformatf("reply %0d %s: expected 0x%0h, got 0x%0h",
					replies_seen, name, want, got));
			end
		endfunction

		// Compare one reply with the oldest prediction.
		function void check_reply(table_reply_t got);
			table_reply_t want;
			replies_seen++;
			if (pending_replies.size() == 0) begin
				flag($sformatf("reply %0d arrived with no request outstanding", replies_seen));
				return;
			end
			want = pending_replies.pop_front();
			check_field("ok", want.ok, got.ok);
			check_field("was_hit", want.hit, got.hit);
			check_field("slot", want.slot, got.slot);
			check_field("rd_addr", want.addr, got.addr);
			check_field("rd_kind", want.kind, got.kind);
			check_field("rd_time", want.stamp, got.stamp);
			check_field("entry_total", want.total, got.total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	datt_cmd_t cmd_in = CMD_UPSERT;
	logic [47:0] addr_in = '0;
	logic [7:0] kind_in = '0;
	logic [31:0] time_in = '0;
	logic [3:0] idx_in = '0;
	logic busy, done, ok, was_hit;
	logic [3:0] slot;
	logic [47:0] rd_addr;
	logic [7:0] rd_kind;
	logic [31:0] rd_time;
	logic [4:0] entry_total;

	address_table_tracker table_sb = new();
	logic [47:0] addr_pool[POOL_SIZE];
	int unsigned issued = 0;

	device_address_table_core #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd_in),
		.dev_addr(addr_in),
		.dev_kind(kind_in),
		.now_time(time_in),
		.slot_index(idx_in),
		.done(done),
		.ok(ok),
		.was_hit(was_hit),
		.slot(slot),
		.rd_addr(rd_addr),
		.rd_kind(rd_kind),
		.rd_time(rd_time),
		.entry_total(entry_total)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both sides of the block at every rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				table_sb.check_reply({ok, was_hit, slot, rd_addr, rd_kind, rd_time, entry_total});
			end
			if (start && !busy) begin
				table_sb.log_request(cmd_in, addr_in, kind_in, time_in, idx_in);
			end
		end
	end

	function automatic logic [47:0] fresh_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic issue_request(datt_cmd_t op, logic [47:0] a, logic [7:0] k,
			logic [31:0] t, logic [3:0] idx);
		start <= 1'b1;
		cmd_in <= op;
		addr_in <= a;
		kind_in <= k;
		time_in <= t;
		idx_in <= idx;
		do begin
			@(posedge clk);
		end while (busy);
		issued++;
	endtask

	// Drop start for a burst of cycles while the operand lines carry noise.
	task automatic idle_burst();
		int n;
		n = $urandom_range(1, 10);
		start <= 1'b0;
		cmd_in <= datt_cmd_t'($urandom_range(0, 3));
		addr_in <= fresh_addr();
		kind_in <= 8'($urandom());
		time_in <= $urandom();
		idx_in <= 4'($urandom());
		repeat (n) @(posedge clk);
	endtask

	// Slot index for remove and get: usually a live slot, sometimes anything.
	function automatic logic [3:0] pick_index();
		int unsigned cnt;
		cnt = table_sb.live_count;
		if (cnt > 0 && $urandom_range(0, 99) < 80) begin
			return 4'($urandom_range(0, cnt - 1));
		end
		return 4'($urandom_range(0, 15));
	endfunction

	// Upsert key: a stored address, one from the shared pool, or a new one.
	function automatic logic [47:0] pick_addr();
		int unsigned roll, cnt;
		roll = $urandom_range(0, 99);
		cnt = table_sb.live_count;
		if (roll < 35 && cnt > 0) begin
			return table_sb.addr_tab[$urandom_range(0, cnt - 1)];
		end
		if (roll < 75) begin
			return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		return fresh_addr();
	endfunction

	// Append new addresses until the table overflows at least once.
	task automatic fill_table();
		int n;
		n = 18 - int'(table_sb.live_count);
		repeat (n) begin
			issue_request(CMD_UPSERT, fresh_addr(), 8'($urandom()), $urandom(),
				4'($urandom()));
		end
	endtask

	// One random request; the profile sets how the table tends to grow or drain.
	task automatic random_request(int profile);
		int unsigned roll, up_lim, rm_lim, get_lim;
		datt_cmd_t op;
		roll = $urandom_range(0, 99);
		case (profile)
			0: begin up_lim = 70; rm_lim = 78; get_lim = 99; end
			1: begin up_lim = 45; rm_lim = 70; get_lim = 98; end
			default: begin up_lim = 20; rm_lim = 65; get_lim = 99; end
		endcase
		if (roll < up_lim) begin
			op = CMD_UPSERT;
		end else if (roll < rm_lim) begin
			op = CMD_REMOVE;
		end else if (roll < get_lim) begin
			op = CMD_GET;
		end else begin
			op = CMD_CLEAR;
		end
		issue_request(op, (op == CMD_UPSERT) ? pick_addr() : fresh_addr(),
			8'($urandom()), $urandom(), pick_index());
	endtask

	// Main sequence: reset, directed requests, then random blocks.
	initial begin
		int profile, idle_pct, drain_wait;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			if (i >= 12) begin
				// Neighbors that differ from an earlier key in one bit.
				addr_pool[i] = addr_pool[i - 10] ^ (48'd1 << $urandom_range(0, 47));
			end else begin
				addr_pool[i] = fresh_addr();
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: reads and removes are out of range, clear still succeeds.
		issue_request(CMD_GET, '0, '0, '0, 4'd0);
		issue_request(CMD_REMOVE, '0, '0, '0, 4'd0);
		issue_request(CMD_CLEAR, '1, '1, '1, 4'hF);
		// Field extremes, a one-bit neighbor, and a refresh on a hit.
		issue_request(CMD_UPSERT, 48'h0, 8'h00, 32'h0, 4'd0);
		issue_request(CMD_UPSERT, '1, 8'hFF, 32'hFFFF_FFFF, 4'hF);
		issue_request(CMD_UPSERT, 48'h1, 8'h5A, 32'h0000_0001, 4'd0);
		issue_request(CMD_UPSERT, 48'h0, 8'hA5, 32'h1234_5678, 4'd0);
		issue_request(CMD_GET, '0, '0, '0, 4'd0);
		issue_request(CMD_GET, '0, '0, '0, 4'd1);
		issue_request(CMD_GET, '0, '0, '0, 4'd2);
		issue_request(CMD_GET, '0, '0, '0, 4'd3);
		issue_request(CMD_GET, '0, '0, '0, 4'hF);
		// Remove from the middle, then read the record that moved down.
		issue_request(CMD_REMOVE, '0, '0, '0, 4'd1);
		issue_request(CMD_GET, '0, '0, '0, 4'd1);
		issue_request(CMD_REMOVE, '0, '0, '0, 4'd5);
		issue_request(CMD_UPSERT, '1, 8'h80, 32'h8000_0000, 4'd0);
		issue_request(CMD_REMOVE, '0, '0, '0, 4'd0);
		issue_request(CMD_UPSERT, 48'h8000_0000_0000, 8'h7F, 32'h7FFF_FFFF, 4'd0);
		issue_request(CMD_GET, '0, '0, '0, 4'd2);
		issue_request(CMD_CLEAR, '0, '0, '0, 4'd0);
		issue_request(CMD_GET, '0, '0, '0, 4'd0);
		issue_request(CMD_REMOVE, '0, '0, '0, 4'hF);

		// Random part: blocks of 40 requests with a growth profile and idle rate.
		fill_table();
		while (issued < RAND_ITEMS) begin
			profile = $urandom_range(0, 2);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				fill_table();
			end
			repeat (40) begin
				if (issued < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
					idle_burst();
				end
				random_request(profile);
			end
		end
		start <= 1'b0;

		// Let the last replies come out.
		drain_wait = 0;
		while (table_sb.pending() != 0 && drain_wait < 200) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (table_sb.pending() != 0) begin
			table_sb.flag($sformatf("%0d replies never arrived", table_sb.pending()));
		end

		$display("Covered %0d requests: %0d appends, %0d hits, %0d full refusals, %0d removes,",
			table_sb.n_requests, table_sb.n_appends, table_sb.n_hits, table_sb.n_full,
			table_sb.n_removes);
		$display("%0d reads, %0d out-of-range indexes, %0d clears; peak fill %0d; %0d faults.",
			table_sb.n_gets, table_sb.n_range_miss, table_sb.n_clears, table_sb.peak_count,
			table_sb.faults);
		if (table_sb.faults == 0) begin
			$display("device_address_table_core regression: pass");
		end else begin
			$display("device_address_table_core regression: fail");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("device_address_table_core regression: fail");
		$finish;
	end

endmodule
